// ===== hw/rtl/kdh_pkg.sv =====
// Shared types and constants for the key debounce and hold detector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package kdh_pkg;

  // Default sizing of the block.
  localparam int unsigned NumKeysDefault    = 4;
  localparam int unsigned CountWidthDefault = 16;

  // Width of the threshold registers and of the configuration data.
  localparam int unsigned ThreshWidth = 16;
  localparam int unsigned CfgIdxWidth = 1;

  // Reset values of the thresholds.
  localparam logic [ThreshWidth-1:0] DebounceReset = ThreshWidth'(3);
  localparam logic [ThreshWidth-1:0] HoldReset     = ThreshWidth'(100);

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DEBOUNCE = 1'b0,
    REG_HOLD     = 1'b1
  } cfg_reg_e;

  // Logical state of one key.
  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2
  } key_state_e;

  // Event code reported for each sample.
  typedef enum logic [1:0] {
    EV_IDLE     = 2'd0,
    EV_RELEASED = 2'd1,
    EV_PRESSED  = 2'd2,
    EV_HOLD     = 2'd3
  } key_event_e;

  // Threshold settings handed from the register block to the key logic.
  typedef struct packed {
    logic [ThreshWidth-1:0] debounce_count;
    logic [ThreshWidth-1:0] hold_count;
  } kdh_cfg_t;

endpackage

// ===== hw/rtl/kdh_cfg_regs.sv =====
// Threshold registers of the key debounce and hold detector.
// Depends on kdh_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module kdh_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kdh_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [kdh_pkg::ThreshWidth-1:0]     cfg_wdata_i,
  output kdh_pkg::kdh_cfg_t                   cfg_o
);
  import kdh_pkg::*;

  kdh_cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_count <= DebounceReset;
      cfg_q.hold_count     <= HoldReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DEBOUNCE: cfg_q.debounce_count <= cfg_wdata_i;
        REG_HOLD:     cfg_q.hold_count     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/kdh_key_fsm.sv =====
// Next-state and event logic for one key sample.
// Depends on kdh_pkg for the state, event and threshold types.
`timescale 1ns / 1ps

module kdh_key_fsm #(
  parameter int unsigned COUNT_WIDTH = kdh_pkg::CountWidthDefault
) (
  input  kdh_pkg::kdh_cfg_t       cfg_i,
  input  kdh_pkg::key_state_e     state_i,
  input  logic [COUNT_WIDTH-1:0]  press_cnt_i,
  input  logic [COUNT_WIDTH-1:0]  release_cnt_i,
  input  logic                    pin_pressed_i,
  output kdh_pkg::key_state_e     state_o,
  output logic [COUNT_WIDTH-1:0]  press_cnt_o,
  output logic [COUNT_WIDTH-1:0]  release_cnt_o,
  output kdh_pkg::key_event_e     event_o
);
  import kdh_pkg::*;

  localparam int unsigned CmpWidth = (COUNT_WIDTH > ThreshWidth) ? COUNT_WIDTH : ThreshWidth;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] press_inc;
  logic [COUNT_WIDTH-1:0] release_inc;
  logic                   press_deb_hit;
  logic                   press_hold_hit;
  logic                   release_hit;

  // Saturating increments; a threshold beyond the counter range is never met.
  assign press_inc   = (press_cnt_i == CntMax) ? CntMax : press_cnt_i + COUNT_WIDTH'(1);
  assign release_inc = (release_cnt_i == CntMax) ? CntMax : release_cnt_i + COUNT_WIDTH'(1);

  assign press_deb_hit  = CmpWidth'(press_inc)   >= CmpWidth'(cfg_i.debounce_count);
  assign press_hold_hit = CmpWidth'(press_inc)   >= CmpWidth'(cfg_i.hold_count);
  assign release_hit    = CmpWidth'(release_inc) >= CmpWidth'(cfg_i.debounce_count);

  always_comb begin
    state_o       = state_i;
    press_cnt_o   = press_cnt_i;
    release_cnt_o = release_cnt_i;
    event_o       = EV_IDLE;
    case (state_i)
      ST_PRESSED, ST_HELD: begin
        if (pin_pressed_i) begin
          release_cnt_o = '0;
          if (state_i == ST_HELD) begin
            event_o = EV_HOLD;
          end else if (press_hold_hit) begin
            state_o     = ST_HELD;
            press_cnt_o = '0;
            event_o     = EV_HOLD;
          end else begin
            press_cnt_o = press_inc;
          end
        end else if (release_hit) begin
          // The press counter is cleared too, so the next press is debounced in full.
          state_o       = ST_RELEASED;
          press_cnt_o   = '0;
          release_cnt_o = '0;
          event_o       = EV_RELEASED;
        end else begin
          release_cnt_o = release_inc;
        end
      end
      default: begin
        // Released, and the unused code behaves as released.
        state_o = ST_RELEASED;
        if (pin_pressed_i) begin
          if (press_deb_hit) begin
            state_o     = ST_PRESSED;
            press_cnt_o = '0;
            event_o     = EV_PRESSED;
          end else begin
            press_cnt_o = press_inc;
          end
        end else begin
          press_cnt_o = '0;
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/key_debounce_hold_detector.sv =====
// Top level of the key debounce and hold detector: sample register, per-key state,
// result register and assertions. Depends on kdh_pkg, kdh_cfg_regs and kdh_key_fsm.
`timescale 1ns / 1ps

//  Channel   | Direction | Handshake                  | Payload
//  ----------+-----------+----------------------------+------------------------------
//  sample    | in        | in_valid_i / in_stall_o    | key_index_i, pin_pressed_i
//  event     | out       | out_valid_o / out_stall_i  | key_event_o
//  config    | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_wdata_i
//
// A sample request is captured in the sample register; when the result register can
// advance, the key logic reads that key's state, updates it and loads the event into
// the result register. One request is accepted every cycle while in_stall_o is low;
// the per-key state is written at the same edge that loads the result, so back-to-back
// samples of the same key see fresh state.
// Reset puts every key in the released state with both counters at zero, and the
// thresholds at three (debounce) and one hundred (hold).
// A stall on the event channel holds the result register and, once the sample
// register is also full, raises in_stall_o; nothing is dropped.

module key_debounce_hold_detector #(
  parameter int unsigned NUM_KEYS    = kdh_pkg::NumKeysDefault,
  parameter int unsigned COUNT_WIDTH = kdh_pkg::CountWidthDefault,
  localparam int unsigned KeyIdxW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Sample channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [KeyIdxW-1:0]               key_index_i,
  input  logic                             pin_pressed_i,
  // Event channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       key_event_o,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [kdh_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [kdh_pkg::ThreshWidth-1:0]  cfg_wdata_i
);
  import kdh_pkg::*;

  kdh_cfg_t cfg;

  // Sample register.
  logic               s1_valid_q;
  logic [KeyIdxW-1:0] s1_idx_q;
  logic               s1_pin_q;

  // Result register.
  logic       out_valid_q;
  key_event_e key_event_q;

  // Per-key state.
  key_state_e             key_state_q   [NUM_KEYS];
  logic [COUNT_WIDTH-1:0] press_cnt_q   [NUM_KEYS];
  logic [COUNT_WIDTH-1:0] release_cnt_q [NUM_KEYS];

  // Updated state for the key in the sample register.
  key_state_e             state_d;
  logic [COUNT_WIDTH-1:0] press_cnt_d;
  logic [COUNT_WIDTH-1:0] release_cnt_d;
  key_event_e             fsm_event;
  key_event_e             event_d;

  logic in_fire;
  logic advance;
  logic s1_fire;
  logic key_ok;

  kdh_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The result register moves on when it is empty or its event is being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Indexes at or beyond the key count report idle and leave all state alone.
  assign key_ok = {1'b0, s1_idx_q} < (KeyIdxW + 1)'(NUM_KEYS);

  kdh_key_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_key_fsm (
    .cfg_i         (cfg),
    .state_i       (key_state_q[s1_idx_q]),
    .press_cnt_i   (press_cnt_q[s1_idx_q]),
    .release_cnt_i (release_cnt_q[s1_idx_q]),
    .pin_pressed_i (s1_pin_q),
    .state_o       (state_d),
    .press_cnt_o   (press_cnt_d),
    .release_cnt_o (release_cnt_d),
    .event_o       (fsm_event)
  );

  assign event_d = key_ok ? fsm_event : EV_IDLE;

  // Control of the sample and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload of the sample and result registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_idx_q <= key_index_i;
      s1_pin_q <= pin_pressed_i;
    end
    if (s1_fire) begin
      key_event_q <= event_d;
    end
  end

  // Per-key state is written back at the edge that loads the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_state_q[k]   <= ST_RELEASED;
        press_cnt_q[k]   <= '0;
        release_cnt_q[k] <= '0;
      end
    end else if (s1_fire && key_ok) begin
      key_state_q[s1_idx_q]   <= state_d;
      press_cnt_q[s1_idx_q]   <= press_cnt_d;
      release_cnt_q[s1_idx_q] <= release_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_event_o = key_event_q;

  // The sample side is only held back by a full pipeline behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("sample stall raised without a stalled full pipeline");

  // A key index outside the key range always reports idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !key_ok) |=> (out_valid_q && key_event_q == EV_IDLE))
    else $error("out-of-range key produced an event");

  // Press and hold events come from pressed samples, release events from released ones.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (event_d == EV_PRESSED || event_d == EV_HOLD)) |-> s1_pin_q)
    else $error("press or hold reported for a released sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && event_d == EV_RELEASED) |-> !s1_pin_q)
    else $error("release reported for a pressed sample");

endmodule
